// ===== src/pap_pkg.sv =====
// Shared types, codes and header offsets for the proxy-ARP / IPv4 forwarder.
// Used by the front end, the output queue and the top level.
// No dependencies.
`default_nettype none
package pap_pkg;

  // command codes
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_FWD   = 2'd1;
  localparam logic [1:0] CMD_ARP   = 2'd2;

  localparam int DEF_TABLE_ENTRIES = 128;

  // header geometry
  localparam int HDR_BYTES   = 42;
  localparam int ETH_LEN     = 14;
  localparam int ARP_BODY    = 28;
  localparam int IP_MIN      = 34;
  localparam int OFF_ETYPE   = 12;
  localparam int OFF_SRC     = 6;
  localparam int OFF_ARP_OP  = 20;
  localparam int OFF_ARP_SHA = 22;
  localparam int OFF_ARP_SIP = 28;
  localparam int OFF_ARP_THA = 32;
  localparam int OFF_ARP_TIP = 38;
  localparam int OFF_IP_DST  = 30;

  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [15:0] ETYPE_IP  = 16'h0800;
  localparam logic [7:0]  ARP_REPLY = 8'h02;

  localparam int CNT_W = 6;

  typedef struct packed {
    logic [31:0] key;
    logic [47:0] mac;
    logic [31:0] port;
  } entry_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic        verdict;
    logic [31:0] out_port;
  } item_t;

endpackage
`default_nettype wire

// ===== src/pap_if.sv =====
// Valid/ready channel interfaces for the input command stream and the result stream.
// Depends on nothing but the signal widths of the block's fields.
`default_nettype none
interface pap_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  frame_byte;
  logic        frame_last;
  logic [6:0]  slot;
  logic [31:0] entry_key;
  logic [47:0] entry_mac;
  logic [31:0] entry_port;
  logic        entry_valid;

  modport source (output valid, command, frame_byte, frame_last, slot, entry_key,
                  entry_mac, entry_port, entry_valid, input ready);
  modport sink   (input valid, command, frame_byte, frame_last, slot, entry_key,
                  entry_mac, entry_port, entry_valid, output ready);
endinterface

interface pap_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        verdict;
  logic [31:0] out_port;

  modport source (output valid, out_byte, out_last, verdict, out_port, input ready);
  modport sink   (input valid, out_byte, out_last, verdict, out_port, output ready);
endinterface
`default_nettype wire

// ===== src/pap_front.sv =====
// Front end: table writes, header capture, table search, header rewrite and flush.
// Depends on pap_pkg and pap_in_if; pushes result items into the output queue.
`default_nettype none
module pap_front
  import pap_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pap_in_if.sink     in_ch,
  output logic       push_valid,
  output item_t      push_item,
  input  wire logic  push_ready
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] S_COLLECT = 2'd0;
  localparam logic [1:0] S_SEARCH  = 2'd1;
  localparam logic [1:0] S_FLUSH   = 2'd2;

  logic [1:0]       state_r;
  logic             decided_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] rem_r;
  logic             lastf_r;
  logic             verdict_r;
  logic [31:0]      port_r;
  logic [AW-1:0]    scan_r;
  logic             data_ok_r;
  logic             rd_last_r;
  logic [7:0]       win_r [HDR_BYTES];

  logic [TABLE_ENTRIES-1:0] fwd_v_r;
  logic [TABLE_ENTRIES-1:0] arp_v_r;
  entry_t           fwd_mem [TABLE_ENTRIES];
  entry_t           arp_mem [TABLE_ENTRIES];
  entry_t           fwd_rd_r;
  entry_t           arp_rd_r;
  logic             fwd_vrd_r;
  logic             arp_vrd_r;

  logic             acc;
  logic             slot_ok;
  logic [10:0]      slot_ext;
  logic [AW-1:0]    wa;
  logic             fwd_we;
  logic             arp_we;
  entry_t           wr_entry;
  logic             byte_acc;
  logic             trigger;
  logic [15:0]      etype;
  logic             is_arp;
  logic             is_ip;
  logic [31:0]      key;
  entry_t           sel;
  logic             sel_v;
  logic             hit;
  logic             flush_push;

  // accept only while collecting and the queue has room
  assign in_ch.ready = (state_r == S_COLLECT) && push_ready;
  assign acc         = in_ch.valid && in_ch.ready;

  // table write decode
  assign slot_ext = {4'd0, in_ch.slot};
  assign slot_ok  = 32'(slot_ext) < TABLE_ENTRIES;
  assign wa       = slot_ext[AW-1:0];
  assign fwd_we   = acc && (in_ch.command == CMD_FWD) && slot_ok;
  assign arp_we   = acc && (in_ch.command == CMD_ARP) && slot_ok;
  assign wr_entry = '{key: in_ch.entry_key, mac: in_ch.entry_mac, port: in_ch.entry_port};

  assign byte_acc = acc && (in_ch.command == CMD_FRAME);
  assign trigger  = byte_acc && !decided_r &&
                    ((cnt_r == CNT_W'(HDR_BYTES - 1)) || in_ch.frame_last);

  // classify the captured header
  assign etype  = {win_r[OFF_ETYPE], win_r[OFF_ETYPE+1]};
  assign is_arp = (etype == ETYPE_ARP) && (n_r >= CNT_W'(ETH_LEN + ARP_BODY));
  assign is_ip  = (etype == ETYPE_IP) && (n_r >= CNT_W'(IP_MIN));
  assign key    = is_arp ?
                  {win_r[OFF_ARP_SIP], win_r[OFF_ARP_SIP+1],
                   win_r[OFF_ARP_SIP+2], win_r[OFF_ARP_SIP+3]} :
                  {win_r[OFF_IP_DST], win_r[OFF_IP_DST+1],
                   win_r[OFF_IP_DST+2], win_r[OFF_IP_DST+3]};
  assign sel    = is_arp ? arp_rd_r : fwd_rd_r;
  assign sel_v  = is_arp ? arp_vrd_r : fwd_vrd_r;
  assign hit    = (state_r == S_SEARCH) && data_ok_r && (is_arp || is_ip) &&
                  sel_v && (sel.key == key);

  assign flush_push = (state_r == S_FLUSH) && push_ready;

  // result item source: flushed header byte or passed-through byte
  always_comb begin
    push_valid = 1'b0;
    push_item  = '{out_byte: in_ch.frame_byte, out_last: in_ch.frame_last,
                   verdict: verdict_r, out_port: verdict_r ? port_r : 32'd0};
    if (state_r == S_FLUSH) begin
      push_valid = 1'b1;
      push_item  = '{out_byte: win_r[0], out_last: lastf_r && (rem_r == CNT_W'(1)),
                     verdict: verdict_r, out_port: verdict_r ? port_r : 32'd0};
    end else if (byte_acc && decided_r) begin
      push_valid = 1'b1;
    end
  end

  // forward table storage, registered read at the scan address
  always_ff @(posedge clk) begin
    if (fwd_we) fwd_mem[wa] <= wr_entry;
    fwd_rd_r <= fwd_mem[scan_r];
  end

  // proxy-ARP table storage
  always_ff @(posedge clk) begin
    if (arp_we) arp_mem[wa] <= wr_entry;
    arp_rd_r <= arp_mem[scan_r];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= '0;
      arp_v_r <= '0;
    end else begin
      if (fwd_we) fwd_v_r[wa] <= in_ch.entry_valid;
      if (arp_we) arp_v_r[wa] <= in_ch.entry_valid;
    end
    fwd_vrd_r <= fwd_v_r[scan_r];
    arp_vrd_r <= arp_v_r[scan_r];
  end

  // header window: capture, rewrite on a hit, shift out during flush
  always_ff @(posedge clk) begin
    if (byte_acc && !decided_r) begin
      win_r[cnt_r] <= in_ch.frame_byte;
    end else if (hit) begin
      if (is_arp) begin
        for (int k = 0; k < 6; k++) begin
          win_r[k]               <= win_r[OFF_SRC+k];
          win_r[OFF_SRC+k]       <= sel.mac[47-8*k -: 8];
          win_r[OFF_ARP_SHA+k]   <= sel.mac[47-8*k -: 8];
          win_r[OFF_ARP_THA+k]   <= win_r[OFF_SRC+k];
        end
        for (int k = 0; k < 4; k++) begin
          win_r[OFF_ARP_SIP+k] <= win_r[OFF_ARP_TIP+k];
          win_r[OFF_ARP_TIP+k] <= win_r[OFF_ARP_SIP+k];
        end
        win_r[OFF_ARP_OP]   <= 8'h00;
        win_r[OFF_ARP_OP+1] <= ARP_REPLY;
      end else begin
        for (int k = 0; k < 6; k++) win_r[k] <= sel.mac[47-8*k -: 8];
      end
    end else if (flush_push) begin
      for (int k = 0; k < HDR_BYTES - 1; k++) win_r[k] <= win_r[k+1];
    end
  end

  // control: collect, search, flush
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_COLLECT;
      decided_r <= 1'b0;
      cnt_r     <= '0;
      n_r       <= '0;
      rem_r     <= '0;
      lastf_r   <= 1'b0;
      verdict_r <= 1'b0;
      port_r    <= '0;
      scan_r    <= '0;
      data_ok_r <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      case (state_r)
        S_COLLECT: begin
          if (byte_acc && decided_r) begin
            if (in_ch.frame_last) begin
              decided_r <= 1'b0;
              verdict_r <= 1'b0;
              port_r    <= '0;
            end
          end else if (trigger) begin
            n_r       <= cnt_r + CNT_W'(1);
            rem_r     <= cnt_r + CNT_W'(1);
            lastf_r   <= in_ch.frame_last;
            cnt_r     <= '0;
            scan_r    <= '0;
            data_ok_r <= 1'b0;
            state_r   <= S_SEARCH;
          end else if (byte_acc) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_SEARCH: begin
          // advance the scan; the read of slot i is checked in the cycle after it is issued
          data_ok_r <= 1'b1;
          rd_last_r <= (scan_r == LAST_IDX);
          if (scan_r != LAST_IDX) scan_r <= scan_r + AW'(1);
          if (!(is_arp || is_ip)) begin
            verdict_r <= 1'b0;
            port_r    <= '0;
            state_r   <= S_FLUSH;
          end else if (hit) begin
            verdict_r <= 1'b1;
            port_r    <= sel.port;
            state_r   <= S_FLUSH;
          end else if (data_ok_r && rd_last_r) begin
            verdict_r <= 1'b0;
            port_r    <= '0;
            state_r   <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (flush_push) begin
            rem_r <= rem_r - CNT_W'(1);
            if (rem_r == CNT_W'(1)) begin
              state_r   <= S_COLLECT;
              decided_r <= !lastf_r;
              if (lastf_r) begin
                verdict_r <= 1'b0;
                port_r    <= '0;
              end
            end
          end
        end
        default: state_r <= S_COLLECT;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/pap_queue.sv =====
// Back end: small result queue between the front end and the output channel.
// Depends on pap_pkg and pap_out_if.
`default_nettype none
module pap_queue
  import pap_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  input  wire item_t push_item,
  output logic       push_ready,
  pap_out_if.source  out_ch
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  item_t         q_r [DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [PW:0]   cnt_r;
  logic          push;
  logic          pop;

  assign push_ready      = (cnt_r != (PW+1)'(DEPTH));
  assign push            = push_valid && push_ready;
  assign out_ch.valid    = (cnt_r != '0);
  assign pop             = out_ch.valid && out_ch.ready;
  assign out_ch.out_byte = q_r[rp_r].out_byte;
  assign out_ch.out_last = q_r[rp_r].out_last;
  assign out_ch.verdict  = q_r[rp_r].verdict;
  assign out_ch.out_port = q_r[rp_r].out_port;

  // store item
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_item;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== src/proxy_arp_and_ip_forwarder.sv =====
// Proxy-ARP responder with IPv4 next-hop forwarding, top level.
// Depends on pap_pkg, pap_if, pap_front and pap_queue.
//
// in_ch carries commands: frame bytes in wire order, or writes of a forward or
// proxy-ARP table slot. out_ch carries one item per frame byte, possibly
// rewritten, with the verdict and egress port of its frame.
// The first 42 bytes of a frame (fewer if it ends sooner) are held. After the
// byte that completes the header the front end stops accepting and searches
// the selected table one slot a cycle through its registered memory port:
// it first classifies the header and issues the read of slot 0 (a frame
// that needs no search leaves here), then checks one slot per read, up to
// TABLE_ENTRIES slots, until the lowest valid match is found. It then flushes
// the held bytes, one a cycle while the queue has room. Bytes after the header
// are taken one a cycle while the queue has room and are registered in the
// queue before they reach out_ch; table writes are taken alike and give no item.
// A 4-entry queue parts the two sides; when the receiver stalls, the queue
// fills and in_ch.ready drops, and no item is lost.
// Reset (rst_n low, synchronous) clears both tables' valid bits, the frame
// state and the queue; table contents are left as they are.
`default_nettype none
module proxy_arp_and_ip_forwarder
  import pap_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pap_in_if.sink     in_ch,
  pap_out_if.source  out_ch
);

  logic  push_valid;
  item_t push_item;
  logic  push_ready;

  pap_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  pap_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
